// File: rtl/core/frlm_pkg.sv
// frame rate and latency monitor: shared types, constants and codes
package frlm_pkg;

   localparam int FRAMES_AHEAD_DEF     = 128;
   localparam int HISTORY_MAX_DEF      = 64;
   localparam int SAMPLE_PERIOD_MS_DEF = 1000;

   localparam int FRAME_W   = 32;
   localparam int TIME_W    = 32;
   localparam int SAMPLE_W  = 16;
   localparam int AVG_FPS_W = 16;
   localparam int AVG_LAT_W = 24;
   localparam int LEN_W     = 7;
   localparam int FRAC_W    = 8;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = LEN_W;
   localparam logic [CSR_IDX_W-1:0] CSR_FPS_LEN = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LAT_LEN = 1'b1;

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_RESP = 1'b1;

   localparam logic [SAMPLE_W-1:0]  FPS_INIT     = 16'd7680;
   localparam logic [SAMPLE_W-1:0]  LAT_INIT     = 16'd200;
   localparam logic [LEN_W-1:0]     LEN_RESET    = 7'd16;
   localparam logic [AVG_LAT_W-1:0] AVG_LAT_INIT = 24'd51200;

   localparam int DVD_W      = 32;
   localparam int DIV_STEPS  = DVD_W / 2;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

   typedef struct packed {
      logic                cmd;
      logic [FRAME_W-1:0]  frame;
      logic [TIME_W-1:0]   now_ms;
      logic [SAMPLE_W-1:0] fps_sample;
   } frlm_req_type;

   typedef struct packed {
      logic [AVG_FPS_W-1:0] avg_fps;
      logic [AVG_LAT_W-1:0] avg_latency;
      logic                 fps_updated;
   } frlm_rsp_type;

   typedef enum logic [1:0] {
      DIV_RING = 2'd0,
      DIV_IDX  = 2'd1,
      DIV_FPS  = 2'd2,
      DIV_LAT  = 2'd3
   } frlm_div_sel_type;

   typedef struct packed {
      logic             clear;
      logic             capture;
      logic             div_start;
      logic             div_store;
      frlm_div_sel_type div_sel;
      logic             lookup;
      logic             update;
      logic             reply;
   } frlm_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic div_busy;
      logic is_resp;
      logic took_sample;
      logic out_busy;
   } frlm_stat_type;

endpackage

// File: rtl/core/frlm_divider.sv
// shared restoring divider, two quotient bits per cycle
module frlm_divider import frlm_pkg::*; #(
   parameter int DIV_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic             busy,
   output logic [DVD_W-1:0] quotient,
   output logic [DIV_W-1:0] remainder
);

   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0]     acc_ff, acc_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     div_ff, div_in;

   logic [DIV_W:0]   trial1, trial2;
   logic [DIV_W-1:0] rem1, rem2;
   logic             qbit1, qbit2;

   always_comb begin
      trial1 = {rem_ff, acc_ff[DVD_W-1]};
      qbit1  = trial1 >= {1'b0, div_ff};
      rem1   = qbit1 ? DIV_W'(trial1 - {1'b0, div_ff}) : trial1[DIV_W-1:0];
      trial2 = {rem1, acc_ff[DVD_W-2]};
      qbit2  = trial2 >= {1'b0, div_ff};
      rem2   = qbit2 ? DIV_W'(trial2 - {1'b0, div_ff}) : trial2[DIV_W-1:0];

      cnt_in = cnt_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      if (start) begin
         cnt_in = DIV_CNT_W'(DIV_STEPS);
         acc_in = dividend;
         rem_in = '0;
         div_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         acc_in = {acc_ff[DVD_W-3:0], qbit1, qbit2};
         rem_in = rem2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign busy      = cnt_ff != '0;
   assign quotient  = acc_ff;
   assign remainder = rem_ff;

   a_div_length : assert property (@(posedge clock) disable iff (reset)
      start |-> ##(DIV_STEPS + 1) !busy)
      else $error("divider did not finish in the expected number of cycles");

   a_div_rem : assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> (rem_ff < div_ff))
      else $error("divider remainder not below divisor");

endmodule

// File: rtl/core/frlm_datapath.sv
// datapath: histories, running sums, send time memory, divider and result register
module frlm_datapath import frlm_pkg::*; #(
   parameter int FRAMES_AHEAD     = FRAMES_AHEAD_DEF,
   parameter int HISTORY_MAX      = HISTORY_MAX_DEF,
   parameter int SAMPLE_PERIOD_MS = SAMPLE_PERIOD_MS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  frlm_req_type          req_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output frlm_rsp_type          rsp_data,
   input  frlm_cmd_type          ctl,
   output frlm_stat_type         stat
);

   localparam int RING_W  = $clog2(FRAMES_AHEAD);
   localparam int IDX_W   = (HISTORY_MAX > 1) ? $clog2(HISTORY_MAX) : 1;
   localparam int SUM_W   = SAMPLE_W + IDX_W;
   localparam int RING_DW = $clog2(FRAMES_AHEAD + 1);
   localparam int DIV_W   = (RING_DW > LEN_W) ? RING_DW : LEN_W;
   localparam logic [RING_W-1:0] CLR_LAST = RING_W'(FRAMES_AHEAD - 1);
   localparam logic [SUM_W-1:0]  FPS_SUM_RESET = SUM_W'(32'(FPS_INIT) * 32'(LEN_RESET));
   localparam logic [SUM_W-1:0]  LAT_SUM_RESET = SUM_W'(32'(LAT_INIT) * 32'(LEN_RESET));

   frlm_req_type              req_ff, req_in;
   logic [LEN_W-1:0]          fps_len_ff, fps_len_in;
   logic [LEN_W-1:0]          lat_len_ff, lat_len_in;
   logic [SUM_W-1:0]          fps_sum_ff, fps_sum_in;
   logic [SUM_W-1:0]          lat_sum_ff, lat_sum_in;
   logic [IDX_W-1:0]          fps_slot_ff, fps_slot_in;
   logic [IDX_W-1:0]          slot_sel_ff, slot_sel_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic [RING_W-1:0]         ring_ff, ring_in;
   logic [RING_W-1:0]         clr_ff, clr_in;
   logic [TIME_W-1:0]         last_time_ff, last_time_in;
   logic [HISTORY_MAX-1:0]    fps_vld_ff, fps_vld_in;
   logic [HISTORY_MAX-1:0]    lat_vld_ff, lat_vld_in;
   logic                      fps_vrd_ff, fps_vrd_in;
   logic                      lat_vrd_ff, lat_vrd_in;
   logic                      take_ff, take_in;
   logic [AVG_FPS_W-1:0]      avg_fps_ff, avg_fps_in;
   logic [AVG_LAT_W-1:0]      avg_lat_ff, avg_lat_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   frlm_rsp_type              rsp_ff, rsp_in;

   logic [SAMPLE_W-1:0] fps_mem [HISTORY_MAX];
   logic [SAMPLE_W-1:0] lat_mem [HISTORY_MAX];
   logic [TIME_W-1:0]   send_mem [FRAMES_AHEAD];
   logic [SAMPLE_W-1:0] fps_rd_ff;
   logic [SAMPLE_W-1:0] lat_rd_ff;
   logic [TIME_W-1:0]   send_rd_ff;

   logic [IDX_W-1:0]    fps_slot_cur;
   logic [TIME_W-1:0]   since_last;
   logic                sample_due;
   logic [SAMPLE_W-1:0] fps_old, lat_old, lat_new;
   logic [TIME_W-1:0]   lat_age;
   logic [SUM_W-1:0]    fps_sum_new, lat_sum_new;
   logic [IDX_W-1:0]    slot_next;
   logic [LEN_W-1:0]    len_clamped;
   logic                is_tick;

   logic             div_start;
   logic [DVD_W-1:0] div_dividend;
   logic [DIV_W-1:0] div_divisor;
   logic             div_busy;
   logic [DVD_W-1:0] div_quot;
   logic [DIV_W-1:0] div_rem;

   frlm_divider #(
      .DIV_W (DIV_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   always_comb begin
      is_tick      = req_ff.cmd == CMD_TICK;
      fps_slot_cur = (32'(fps_slot_ff) >= 32'(fps_len_ff)) ? '0 : fps_slot_ff;
      since_last   = req_ff.now_ms - last_time_ff;
      sample_due   = !since_last[TIME_W-1] && (since_last >= TIME_W'(SAMPLE_PERIOD_MS));
      fps_old      = fps_vrd_ff ? fps_rd_ff : FPS_INIT;
      lat_old      = lat_vrd_ff ? lat_rd_ff : LAT_INIT;
      fps_sum_new  = fps_sum_ff - SUM_W'(fps_old) + SUM_W'(req_ff.fps_sample);
      lat_age      = req_ff.now_ms - send_rd_ff;
      if (lat_age[TIME_W-1]) begin
         lat_new = '0;
      end else if (lat_age[TIME_W-2:SAMPLE_W] != '0) begin
         lat_new = '1;
      end else begin
         lat_new = lat_age[SAMPLE_W-1:0];
      end
      lat_sum_new = lat_sum_ff - SUM_W'(lat_old) + SUM_W'(lat_new);
      slot_next   = (32'(slot_sel_ff) + 32'd1 >= 32'(fps_len_ff)) ? '0
                                                                 : slot_sel_ff + IDX_W'(1);
      if (csr_wdata == '0) begin
         len_clamped = LEN_W'(1);
      end else if (32'(csr_wdata) > 32'(HISTORY_MAX)) begin
         len_clamped = LEN_W'(HISTORY_MAX);
      end else begin
         len_clamped = csr_wdata;
      end

      div_start = ctl.div_start;
      case (ctl.div_sel)
         DIV_RING: begin
            div_dividend = req_ff.frame;
            div_divisor  = DIV_W'(FRAMES_AHEAD);
         end
         DIV_IDX: begin
            div_dividend = req_ff.frame;
            div_divisor  = DIV_W'(lat_len_ff);
         end
         DIV_FPS: begin
            div_dividend = DVD_W'(fps_sum_ff);
            div_divisor  = DIV_W'(fps_len_ff);
         end
         DIV_LAT: begin
            div_dividend = DVD_W'({lat_sum_ff, {FRAC_W{1'b0}}});
            div_divisor  = DIV_W'(lat_len_ff);
         end
         default: begin
            div_dividend = req_ff.frame;
            div_divisor  = DIV_W'(FRAMES_AHEAD);
         end
      endcase
   end

   always_comb begin
      req_in       = req_ff;
      fps_len_in   = fps_len_ff;
      lat_len_in   = lat_len_ff;
      fps_sum_in   = fps_sum_ff;
      lat_sum_in   = lat_sum_ff;
      fps_slot_in  = fps_slot_ff;
      slot_sel_in  = slot_sel_ff;
      idx_in       = idx_ff;
      ring_in      = ring_ff;
      clr_in       = clr_ff;
      last_time_in = last_time_ff;
      fps_vld_in   = fps_vld_ff;
      lat_vld_in   = lat_vld_ff;
      fps_vrd_in   = fps_vrd_ff;
      lat_vrd_in   = lat_vrd_ff;
      take_in      = take_ff;
      avg_fps_in   = avg_fps_ff;
      avg_lat_in   = avg_lat_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (ctl.clear) begin
         clr_in = clr_ff + RING_W'(1);
      end
      if (ctl.capture) begin
         req_in  = req_data;
         ring_in = req_data.frame[RING_W-1:0];
      end
      if (ctl.div_store) begin
         case (ctl.div_sel)
            DIV_RING: ring_in    = RING_W'(div_rem);
            DIV_IDX:  idx_in     = IDX_W'(div_rem);
            DIV_FPS:  avg_fps_in = div_quot[AVG_FPS_W-1:0];
            DIV_LAT:  avg_lat_in = div_quot[AVG_LAT_W-1:0];
            default:  ring_in    = ring_ff;
         endcase
      end
      if (ctl.lookup) begin
         slot_sel_in = fps_slot_cur;
         take_in     = sample_due;
         fps_vrd_in  = fps_vld_ff[fps_slot_cur];
         lat_vrd_in  = lat_vld_ff[idx_ff];
      end
      if (ctl.update) begin
         if (is_tick) begin
            if (take_ff) begin
               fps_sum_in              = fps_sum_new;
               fps_vld_in[slot_sel_ff] = 1'b1;
               fps_slot_in             = slot_next;
               last_time_in            = req_ff.now_ms;
            end
         end else begin
            lat_sum_in         = lat_sum_new;
            lat_vld_in[idx_ff] = 1'b1;
         end
      end

      if (ctl.reply) begin
         rsp_valid_in       = 1'b1;
         rsp_in.avg_fps     = avg_fps_ff;
         rsp_in.avg_latency = avg_lat_ff;
         rsp_in.fps_updated = is_tick && take_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_we) begin
         case (csr_index)
            CSR_FPS_LEN: begin
               fps_len_in  = len_clamped;
               fps_sum_in  = SUM_W'(32'(FPS_INIT) * 32'(len_clamped));
               fps_slot_in = '0;
               fps_vld_in  = '0;
               avg_fps_in  = FPS_INIT;
            end
            CSR_LAT_LEN: begin
               lat_len_in = len_clamped;
               lat_sum_in = SUM_W'(32'(LAT_INIT) * 32'(len_clamped));
               lat_vld_in = '0;
               avg_lat_in = AVG_LAT_INIT;
            end
            default: begin
               fps_len_in = fps_len_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fps_len_ff   <= LEN_RESET;
         lat_len_ff   <= LEN_RESET;
         fps_sum_ff   <= FPS_SUM_RESET;
         lat_sum_ff   <= LAT_SUM_RESET;
         fps_slot_ff  <= '0;
         clr_ff       <= '0;
         last_time_ff <= '0;
         fps_vld_ff   <= '0;
         lat_vld_ff   <= '0;
         avg_fps_ff   <= FPS_INIT;
         avg_lat_ff   <= AVG_LAT_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         fps_len_ff   <= fps_len_in;
         lat_len_ff   <= lat_len_in;
         fps_sum_ff   <= fps_sum_in;
         lat_sum_ff   <= lat_sum_in;
         fps_slot_ff  <= fps_slot_in;
         clr_ff       <= clr_in;
         last_time_ff <= last_time_in;
         fps_vld_ff   <= fps_vld_in;
         lat_vld_ff   <= lat_vld_in;
         avg_fps_ff   <= avg_fps_in;
         avg_lat_ff   <= avg_lat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      slot_sel_ff <= slot_sel_in;
      idx_ff      <= idx_in;
      ring_ff     <= ring_in;
      fps_vrd_ff  <= fps_vrd_in;
      lat_vrd_ff  <= lat_vrd_in;
      take_ff     <= take_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (ctl.update && is_tick && take_ff) begin
         fps_mem[slot_sel_ff] <= req_ff.fps_sample;
      end
      if (ctl.lookup) begin
         fps_rd_ff <= fps_mem[fps_slot_cur];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.update && !is_tick) begin
         lat_mem[idx_ff] <= lat_new;
      end
      if (ctl.lookup) begin
         lat_rd_ff <= lat_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         send_mem[clr_ff] <= '0;
      end else if (ctl.lookup && is_tick) begin
         send_mem[ring_ff] <= req_ff.now_ms;
      end
      if (ctl.lookup) begin
         send_rd_ff <= send_mem[ring_ff];
      end
   end

   assign stat.clear_done  = clr_ff == CLR_LAST;
   assign stat.div_busy    = div_busy;
   assign stat.is_resp     = req_ff.cmd == CMD_RESP;
   assign stat.took_sample = take_ff;
   assign stat.out_busy    = rsp_valid_ff && !rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_slot_range : assert property (@(posedge clock) disable iff (reset)
      32'(fps_slot_ff) < 32'(fps_len_ff))
      else $error("frame rate slot beyond history length");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      ctl.reply |-> !(rsp_valid_ff && !rsp_ready))
      else $error("result word overwritten before it was taken");

   a_resp_no_update : assert property (@(posedge clock) disable iff (reset)
      (ctl.reply && req_ff.cmd == CMD_RESP) |=> !rsp_ff.fps_updated)
      else $error("latency response flagged a frame rate update");

endmodule

// File: rtl/core/frlm_ctrl.sv
// controller: sequences clearing, divisions, lookup, update and reply
module frlm_ctrl import frlm_pkg::*; #(
   parameter int FRAMES_AHEAD = FRAMES_AHEAD_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output frlm_cmd_type  ctl,
   input  frlm_stat_type stat
);

   localparam bit RING_POW2 = (FRAMES_AHEAD & (FRAMES_AHEAD - 1)) == 0;

   typedef enum logic [10:0] {
      ST_CLEAR     = 11'b000_0000_0001,
      ST_IDLE      = 11'b000_0000_0010,
      ST_RING_GO   = 11'b000_0000_0100,
      ST_RING_WAIT = 11'b000_0000_1000,
      ST_IDX_GO    = 11'b000_0001_0000,
      ST_IDX_WAIT  = 11'b000_0010_0000,
      ST_LOOKUP    = 11'b000_0100_0000,
      ST_UPDATE    = 11'b000_1000_0000,
      ST_AVG_GO    = 11'b001_0000_0000,
      ST_AVG_WAIT  = 11'b010_0000_0000,
      ST_REPLY     = 11'b100_0000_0000
   } frlm_state_type;

   frlm_state_type   state_ff, state_in;
   frlm_div_sel_type avg_sel;

   always_comb begin
      avg_sel  = stat.is_resp ? DIV_LAT : DIV_FPS;
      state_in = state_ff;
      ctl      = '0;
      ctl.div_sel = DIV_RING;
      case (state_ff)
         ST_CLEAR: begin
            ctl.clear = 1'b1;
            if (stat.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               ctl.capture = 1'b1;
               state_in    = RING_POW2 ? ST_IDX_GO : ST_RING_GO;
            end
         end
         ST_RING_GO: begin
            ctl.div_start = 1'b1;
            ctl.div_sel   = DIV_RING;
            state_in      = ST_RING_WAIT;
         end
         ST_RING_WAIT: begin
            ctl.div_sel = DIV_RING;
            if (!stat.div_busy) begin
               ctl.div_store = 1'b1;
               state_in      = ST_IDX_GO;
            end
         end
         ST_IDX_GO: begin
            ctl.div_sel = DIV_IDX;
            if (stat.is_resp) begin
               ctl.div_start = 1'b1;
               state_in      = ST_IDX_WAIT;
            end else begin
               state_in = ST_LOOKUP;
            end
         end
         ST_IDX_WAIT: begin
            ctl.div_sel = DIV_IDX;
            if (!stat.div_busy) begin
               ctl.div_store = 1'b1;
               state_in      = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            ctl.lookup = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            ctl.update = 1'b1;
            state_in   = (stat.is_resp || stat.took_sample) ? ST_AVG_GO : ST_REPLY;
         end
         ST_AVG_GO: begin
            ctl.div_start = 1'b1;
            ctl.div_sel   = avg_sel;
            state_in      = ST_AVG_WAIT;
         end
         ST_AVG_WAIT: begin
            ctl.div_sel = avg_sel;
            if (!stat.div_busy) begin
               ctl.div_store = 1'b1;
               state_in      = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (!stat.out_busy) begin
               ctl.reply = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;

   a_store_after_busy : assert property (@(posedge clock) disable iff (reset)
      ctl.div_start |=> stat.div_busy)
      else $error("division started but divider not busy");

endmodule

// File: rtl/core/frame_rate_and_latency_monitor_top.sv
// frame rate and latency monitor: top level
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_data  (cmd, frame, now_ms, fps_sample)
//   rsp      out        rsp_valid/rsp_ready  rsp_data  (avg_fps, avg_latency, fps_updated)
//   csr      in         csr_we               csr_index, csr_wdata
//
// one word at a time; a tick without a sample: lookup, update, reply; a tick with a
// sample or a latency response also averages on the shared 2-bit-per-cycle divider,
// a response first divides for its history index, and a ring division leads when
// FRAMES_AHEAD is not a power of two; after reset a clearing pass sweeps send time memory
// a result waits in its output register while the next word is accepted
module frame_rate_and_latency_monitor_top import frlm_pkg::*; #(
   parameter int FRAMES_AHEAD     = FRAMES_AHEAD_DEF,
   parameter int HISTORY_MAX      = HISTORY_MAX_DEF,
   parameter int SAMPLE_PERIOD_MS = SAMPLE_PERIOD_MS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  frlm_req_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output frlm_rsp_type          rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   frlm_cmd_type  ctl;
   frlm_stat_type stat;

   frlm_ctrl #(
      .FRAMES_AHEAD (FRAMES_AHEAD)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .ctl       (ctl),
      .stat      (stat)
   );

   frlm_datapath #(
      .FRAMES_AHEAD     (FRAMES_AHEAD),
      .HISTORY_MAX      (HISTORY_MAX),
      .SAMPLE_PERIOD_MS (SAMPLE_PERIOD_MS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .ctl       (ctl),
      .stat      (stat)
   );

endmodule

// File: bench/frame_rate_and_latency_monitor_top_test.sv
// testbench for the frame rate and latency monitor: every result checked against a predictor
module frame_rate_and_latency_monitor_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import frlm_pkg::*;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   frlm_req_type          req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   frlm_rsp_type          rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_FPS_LEN;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor state
   logic [SAMPLE_W-1:0] fps_window [HISTORY_MAX_DEF];
   logic [SAMPLE_W-1:0] latency_window [HISTORY_MAX_DEF];
   logic [TIME_W-1:0]   stamp_ring [FRAMES_AHEAD_DEF];
   int unsigned         fps_window_len;
   int unsigned         latency_window_len;
   int unsigned         fps_window_sum;
   int unsigned         latency_window_sum;
   int unsigned         fps_write_pos;
   logic [TIME_W-1:0]   last_sample_ms;

   frlm_req_type pending_words [$];
   frlm_rsp_type expected_averages [$];

   int   words_queued    = 0;
   int   results_checked = 0;
   int   fail_count      = 0;
   int   samples_taken   = 0;
   int   responses_seen  = 0;
   int   settings_used   = 1;
   int   send_idle_pct   = 0;
   int   recv_idle_pct   = 0;
   int   send_gap        = 0;
   int   recv_gap        = 0;
   logic req_took        = 1'b0;
   logic long_hold_armed = 1'b0;
   logic long_hold_done  = 1'b0;

   logic [FRAME_W-1:0] next_frame = '0;
   logic [TIME_W-1:0]  clock_ms   = '0;

   frame_rate_and_latency_monitor_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void load_length(input logic [CSR_IDX_W-1:0] index,
                                       input logic [CSR_DATA_W-1:0] value);
      int unsigned len;
      len = (value == 0) ? 1 : (value > HISTORY_MAX_DEF) ? HISTORY_MAX_DEF : 32'(value);
      if (index == CSR_FPS_LEN) begin
         fps_window_len = len;
         foreach (fps_window[i]) fps_window[i] = FPS_INIT;
         fps_window_sum = FPS_INIT * len;
         fps_write_pos  = 0;
      end else begin
         latency_window_len = len;
         foreach (latency_window[i]) latency_window[i] = LAT_INIT;
         latency_window_sum = LAT_INIT * len;
      end
   endfunction

   function automatic frlm_rsp_type predict_averages(input frlm_req_type w);
      frlm_rsp_type       r;
      logic [TIME_W-1:0]  gap;
      logic [SAMPLE_W-1:0] lat;
      int unsigned        ring;
      int unsigned        pos;
      r    = '0;
      ring = w.frame % FRAMES_AHEAD_DEF;
      if (w.cmd == CMD_TICK) begin
         gap = w.now_ms - last_sample_ms;
         if (!gap[TIME_W-1] && gap >= SAMPLE_PERIOD_MS_DEF) begin
            pos = (fps_write_pos >= fps_window_len) ? 0 : fps_write_pos;
            fps_window_sum = fps_window_sum - fps_window[pos] + w.fps_sample;
            fps_window[pos] = w.fps_sample;
            pos++;
            fps_write_pos  = (pos >= fps_window_len) ? 0 : pos;
            last_sample_ms = w.now_ms;
            r.fps_updated  = 1'b1;
            samples_taken++;
         end
         stamp_ring[ring] = w.now_ms;
      end else begin
         gap = w.now_ms - stamp_ring[ring];
         if (gap[TIME_W-1])
            lat = '0;
         else if (gap > 65535)
            lat = '1;
         else
            lat = gap[SAMPLE_W-1:0];
         pos = w.frame % latency_window_len;
         latency_window_sum = latency_window_sum - latency_window[pos] + lat;
         latency_window[pos] = lat;
         responses_seen++;
      end
      r.avg_fps     = AVG_FPS_W'(fps_window_sum / fps_window_len);
      r.avg_latency = AVG_LAT_W'((latency_window_sum << FRAC_W) / latency_window_len);
      return r;
   endfunction

   // input side
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            send_gap = $urandom_range(0, 13);
            req_valid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            req_valid <= 1'b1;
            req_data  <= pending_words.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_ready <= 1'b0;
      end else if (long_hold_armed && !long_hold_done) begin
         long_hold_done = 1'b1;
         recv_gap = 399;
         rsp_ready <= 1'b0;
      end else if (recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct) begin
         recv_gap = $urandom_range(0, 13);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      frlm_rsp_type want;
      if (reset) begin
         req_took = 1'b0;
      end else begin
         req_took = req_valid && req_ready;
         if (req_took)
            expected_averages.push_back(predict_averages(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_averages.size() == 0) begin
               fail_count++;
               if (fail_count <= 40)
                  $display("%0t: unexpected word avg_fps %h avg_latency %h fps_updated %b",
                           $time, rsp_data.avg_fps, rsp_data.avg_latency, rsp_data.fps_updated);
            end else begin
               want = expected_averages.pop_front();
               if (rsp_data !== want) begin
                  fail_count++;
                  if (fail_count <= 40)
                     $display("%0t: word %0d avg_fps exp %h got %h, avg_latency exp %h got %h, %s",
                              $time, results_checked, want.avg_fps, rsp_data.avg_fps,
                              want.avg_latency, rsp_data.avg_latency,
                              $sformatf("fps_updated exp %b got %b",
                                        want.fps_updated, rsp_data.fps_updated));
               end
               results_checked++;
            end
         end
      end
   end

   task automatic queue_word(input logic cmd, input logic [FRAME_W-1:0] frame,
                             input logic [TIME_W-1:0] now_ms,
                             input logic [SAMPLE_W-1:0] sample);
      frlm_req_type w;
      w.cmd        = cmd;
      w.frame      = frame;
      w.now_ms     = now_ms;
      w.fps_sample = sample;
      pending_words.push_back(w);
      words_queued++;
   endtask

   task automatic wait_drained();
      do @(negedge clock); while (results_checked != words_queued);
   endtask

   task automatic write_lengths(input logic [CSR_DATA_W-1:0] fps_len,
                                input logic [CSR_DATA_W-1:0] lat_len);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_FPS_LEN;
      csr_wdata <= fps_len;
      load_length(CSR_FPS_LEN, fps_len);
      @(negedge clock);
      csr_index <= CSR_LAT_LEN;
      csr_wdata <= lat_len;
      load_length(CSR_LAT_LEN, lat_len);
      @(negedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // mostly ordered ticks and acks with random content, some noise
   task automatic queue_traffic(input int count);
      int                 pick;
      logic [FRAME_W-1:0] frame_no;
      logic [TIME_W-1:0]  at_ms;
      logic               cmd;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            next_frame++;
            clock_ms += (pick < 3) ? $urandom_range(0, 32'h7FFF_FFFF) : $urandom_range(0, 1400);
            queue_word(CMD_TICK, next_frame, clock_ms, SAMPLE_W'($urandom));
         end else if (pick < 88) begin
            frame_no = next_frame - $urandom_range(0, 140);
            clock_ms += $urandom_range(0, 60);
            at_ms = clock_ms;
            if (pick < 50)
               at_ms += $urandom_range(60000, 70000);
            else if (pick < 53)
               at_ms -= $urandom_range(1, 3000);
            queue_word(CMD_RESP, frame_no, at_ms, SAMPLE_W'($urandom));
         end else begin
            cmd   = 1'($urandom_range(0, 1));
            at_ms = $urandom;
            if (cmd == CMD_TICK)
               clock_ms = at_ms;
            queue_word(cmd, $urandom, at_ms, SAMPLE_W'($urandom));
         end
      end
   endtask

   initial begin
      #4_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      load_length(CSR_FPS_LEN, LEN_RESET);
      load_length(CSR_LAT_LEN, LEN_RESET);
      foreach (stamp_ring[i]) stamp_ring[i] = '0;
      last_sample_ms = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 20;
      recv_idle_pct = 20;
      queue_word(CMD_RESP, 32'd5, 32'd300, 16'h0000);
      queue_word(CMD_TICK, 32'd0, 32'd999, 16'hFFFF);
      queue_word(CMD_TICK, 32'd1, 32'd1000, 16'hFFFF);
      queue_word(CMD_TICK, 32'd2, 32'd1999, 16'h0000);
      queue_word(CMD_TICK, 32'd3, 32'd2000, 16'h0000);
      queue_word(CMD_RESP, 32'd3, 32'd2000, 16'hFFFF);
      queue_word(CMD_RESP, 32'd1, 32'd0, 16'h0000);
      queue_word(CMD_TICK, 32'd127, 32'h0000_1000, 16'h1234);
      queue_word(CMD_RESP, 32'd127, 32'h0001_0FFF, 16'h0000);
      queue_word(CMD_TICK, 32'd255, 32'h0002_0000, 16'h8000);
      queue_word(CMD_RESP, 32'd255, 32'h0003_0000, 16'h0000);
      queue_word(CMD_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hAAAA);
      queue_word(CMD_TICK, 32'hFFFF_FFFE, 32'h8002_0000, 16'h5555);
      queue_word(CMD_TICK, 32'h7FFF_FFFF, 32'h8001_FFFF, 16'h5555);
      queue_word(CMD_RESP, 32'hFFFF_FFFF, 32'h0000_0010, 16'h0000);
      queue_word(CMD_RESP, 32'h8000_0000, 32'hFFFF_FFFF, 16'h0000);
      wait_drained();
      clock_ms   = 32'h8001_FFFF;
      next_frame = 32'd1000;

      // zero and above the top both clamp
      write_lengths(7'd0, 7'd127);
      send_idle_pct = 25;
      recv_idle_pct = 25;
      queue_traffic(100);
      wait_drained();

      write_lengths(7'd1, 7'd1);
      send_idle_pct = 0;
      recv_idle_pct = 30;
      queue_traffic(90);
      wait_drained();

      // long result stall so the input backs up
      write_lengths(7'd64, 7'd64);
      send_idle_pct = 30;
      recv_idle_pct = 0;
      long_hold_armed = 1'b1;
      queue_traffic(100);
      wait_drained();

      write_lengths(7'd65, 7'd2);
      send_idle_pct = 15;
      recv_idle_pct = 15;
      queue_traffic(90);
      wait_drained();

      write_lengths(CSR_DATA_W'($urandom_range(0, 127)), CSR_DATA_W'($urandom_range(0, 127)));
      send_idle_pct = 40;
      recv_idle_pct = 40;
      queue_traffic(100);
      wait_drained();

      write_lengths(7'd33, 7'd64);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_traffic(150);
      wait_drained();

      repeat (60) @(negedge clock);
      if (expected_averages.size() != 0) begin
         fail_count++;
         $display("%0t: %0d expected words never arrived", $time, expected_averages.size());
      end
      $display("covered %0d words over %0d length settings", words_queued, settings_used);
      $display("%0d ticks took a frame rate sample, %0d latency responses measured",
               samples_taken, responses_seen);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
